### rtl/core/lwe_pkg.sv
// ----------------------------------------------------------------------------
// lwe_pkg: shared types and constants for the lattice wavevector enumerator
// Field widths, result buffer sizing and the status word of the root unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lwe_pkg;

  // Field widths
  localparam int IN_W   = 10;
  localparam int MAG_W  = 11;
  localparam int COMP_W = 6;

  // Result buffer sizing
  localparam int MAX_RESULTS      = 64;
  localparam int ADDR_W           = $clog2(MAX_RESULTS);
  localparam int CNT_W            = $clog2(MAX_RESULTS + 1);
  localparam int MAX_SQ_MAGNITUDE = 1023;

  // Status word returned by the root unit
  typedef struct packed {
    logic              done;
    logic              exact;
    logic [COMP_W-1:0] root;
  } sqrt_res_t;

endpackage

### rtl/core/lattice_wavevector_enumerator_unit.sv
// ----------------------------------------------------------------------------
// lattice_wavevector_enumerator_unit: integer lattice points on a sphere
// Lists every non-negative integer vector of a given squared length.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with target_sq_magnitude while busy is low; the request word
//   is taken at that edge. busy drops in the cycle that carries the last
//   result, so a new word can be taken at the edge that ends it.
//   The block scans sorted triples i <= j <= k, ascending i then j, taking k
//   from a single six-step floor square root unit. Each hit is written with
//   its distinct permutations into a 64-entry result buffer. If nothing is
//   found the magnitude is raised by one and the scan repeats.
//   Once the scan ends, results leave one per cycle on strobe, each carrying
//   the vector, the magnitude used, is_last and truncated (more vectors than
//   the buffer holds; the excess is dropped).
// Scan steps:
//   Each (i, j) pair takes a bound check and a run of the root unit, each new
//   i a failing j check and an i check, and each stored vector its own write.
//   A request whose magnitude has no vectors also scans the next magnitude.
//   After the last bound check the sequencer passes through S_NDONE and S_EMIT
//   before the first result is strobed out of the registered buffer read.
// Reset clears the sequencer and the strobe; the buffer needs no clearing.
// The receiver cannot stall: results are strobed for exactly one cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lattice_wavevector_enumerator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [lwe_pkg::IN_W-1:0]    target_sq_magnitude,
  output logic                        strobe,
  output logic [lwe_pkg::COMP_W-1:0]  comp_x,
  output logic [lwe_pkg::COMP_W-1:0]  comp_y,
  output logic [lwe_pkg::COMP_W-1:0]  comp_z,
  output logic [lwe_pkg::MAG_W-1:0]   corrected_sq_magnitude,
  output logic                        is_last,
  output logic                        truncated
);
  import lwe_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ICHK  = 3'd1;
  localparam logic [2:0] S_JCHK  = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;
  localparam logic [2:0] S_NDONE = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  localparam int VEC_W = 3 * COMP_W;
  localparam int SQ_W  = MAG_W + 1;

  logic [2:0]          state;
  logic [MAG_W-1:0]    n;
  logic [COMP_W-1:0]   i;
  logic [COMP_W-1:0]   j;
  logic [COMP_W-1:0]   k;
  logic [SQ_W-1:0]     ii;
  logic [SQ_W-1:0]     jj;
  logic [MAG_W-1:0]    rest;
  logic [2:0]          perm;
  logic [CNT_W-1:0]    count;
  logic                over;
  logic [ADDR_W-1:0]   rd_addr;
  logic [VEC_W-1:0]    rd_data;
  logic                last_rd;
  logic                out_last;
  logic                out_strobe;

  logic [VEC_W-1:0]    vec_mem [MAX_RESULTS];

  logic                sq_go;
  logic [MAG_W-1:0]    sq_operand;
  sqrt_res_t           sq_res;

  logic                i_ok;
  logic                j_ok;
  logic                all_eq;
  logic                two_eq;
  logic                perm_end;
  logic                wr_en;
  logic                rd_en;
  logic [VEC_W-1:0]    perm_vec;
  logic [IN_W-1:0]     sat_in;

  // Pick one permutation of the sorted triple (a, b, c)
  function automatic logic [VEC_W-1:0] pick_perm(
    input logic [COMP_W-1:0] a,
    input logic [COMP_W-1:0] b,
    input logic [COMP_W-1:0] c,
    input logic [2:0]        p,
    input logic              distinct
  );
    logic [VEC_W-1:0] v;
    v = {a, b, c};
    if (distinct) begin
      case (p)
        3'd0:    v = {a, b, c};
        3'd1:    v = {a, c, b};
        3'd2:    v = {b, a, c};
        3'd3:    v = {b, c, a};
        3'd4:    v = {c, a, b};
        3'd5:    v = {c, b, a};
        default: v = {a, b, c};
      endcase
    end else begin
      case (p)
        3'd0:    v = {a, b, c};
        3'd1:    v = {b, c, a};
        3'd2:    v = {c, a, b};
        default: v = {a, b, c};
      endcase
    end
    return v;
  endfunction

  // Loop bounds: 3*i*i <= n and 2*j*j <= n - i*i
  assign i_ok = (({1'b0, ii} + {ii, 1'b0}) <= (SQ_W+1)'(n));
  assign j_ok = ({jj, 1'b0} <= (SQ_W+1)'(rest));

  // Triple kind decides the permutation list
  assign all_eq   = (i == j) && (j == k);
  assign two_eq   = (i == j) || (j == k);
  assign perm_end = all_eq || (two_eq && perm == 3'd2) || perm == 3'd5;
  assign perm_vec = pick_perm(i, j, k, perm, !two_eq);

  assign sq_go      = (state == S_JCHK) && j_ok;
  assign sq_operand = MAG_W'({1'b0, rest} - jj);
  assign wr_en      = (state == S_PUT) && (count != CNT_W'(MAX_RESULTS));
  assign rd_en      = (state == S_EMIT);
  assign last_rd    = ({1'b0, rd_addr} == CNT_W'(count - CNT_W'(1)));
  assign sat_in     = (32'(target_sq_magnitude) > MAX_SQ_MAGNITUDE) ?
                      IN_W'(MAX_SQ_MAGNITUDE) : target_sq_magnitude;

  lwe_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .go      (sq_go),
    .operand (sq_operand),
    .res     (sq_res)
  );

  // Sequencer: scan i, scan j, take the root, store permutations, rescan or emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n     <= {1'b0, sat_in};
            i     <= '0;
            ii    <= '0;
            count <= '0;
            over  <= 1'b0;
            state <= S_ICHK;
          end
        end
        S_ICHK: begin
          if (i_ok) begin
            rest  <= MAG_W'({1'b0, n} - ii);
            j     <= i;
            jj    <= ii;
            state <= S_JCHK;
          end else begin
            state <= S_NDONE;
          end
        end
        S_JCHK: begin
          if (j_ok) begin
            state <= S_SQRT;
          end else begin
            i     <= i + COMP_W'(1);
            ii    <= ii + {{(SQ_W-COMP_W-1){1'b0}}, i, 1'b1};
            state <= S_ICHK;
          end
        end
        S_SQRT: begin
          if (sq_res.done) begin
            if (sq_res.exact) begin
              k     <= sq_res.root;
              perm  <= '0;
              state <= S_PUT;
            end else begin
              j     <= j + COMP_W'(1);
              jj    <= jj + {{(SQ_W-COMP_W-1){1'b0}}, j, 1'b1};
              state <= S_JCHK;
            end
          end
        end
        S_PUT: begin
          if (wr_en) begin
            count <= count + CNT_W'(1);
          end else begin
            over <= 1'b1;
          end
          if (perm_end) begin
            j     <= j + COMP_W'(1);
            jj    <= jj + {{(SQ_W-COMP_W-1){1'b0}}, j, 1'b1};
            state <= S_JCHK;
          end else begin
            perm <= perm + 3'd1;
          end
        end
        S_NDONE: begin
          if (count == '0) begin
            // nothing found: raise the magnitude and rescan
            n     <= n + MAG_W'(1);
            i     <= '0;
            ii    <= '0;
            state <= S_ICHK;
          end else begin
            rd_addr <= '0;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          out_strobe <= 1'b1;
          out_last   <= last_rd;
          rd_addr    <= rd_addr + ADDR_W'(1);
          if (last_rd) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result buffer: one write port, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vec_mem[count[ADDR_W-1:0]] <= perm_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vec_mem[rd_addr];
    end
  end

  assign busy                   = (state != S_IDLE);
  assign strobe                 = out_strobe;
  assign comp_x                 = rd_data[VEC_W-1 -: COMP_W];
  assign comp_y                 = rd_data[2*COMP_W-1 -: COMP_W];
  assign comp_z                 = rd_data[COMP_W-1:0];
  assign corrected_sq_magnitude = n;
  assign is_last                = out_last;
  assign truncated              = over;

endmodule

### rtl/core/lwe_sqrt.sv
// ----------------------------------------------------------------------------
// lwe_sqrt: iterative integer floor square root
// Restoring digit recurrence, one root bit per cycle, with an exactness flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwe_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [lwe_pkg::MAG_W-1:0]  operand,
  output lwe_pkg::sqrt_res_t         res
);
  import lwe_pkg::*;

  logic [MAG_W-1:0] rem;
  logic [MAG_W-1:0] root;
  logic [MAG_W-1:0] bitv;
  logic             run;
  logic             done;
  logic [MAG_W:0]   trial;
  logic             take;

  // Trial subtraction for the current bit position
  assign trial = {1'b0, root} + {1'b0, bitv};
  assign take  = ({1'b0, rem} >= trial);

  // Load, then step the recurrence down two bit positions a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem  <= operand;
        root <= '0;
        bitv <= {1'b1, {(MAG_W-1){1'b0}}};
        run  <= 1'b1;
      end else if (run) begin
        if (take) begin
          rem  <= MAG_W'({1'b0, rem} - trial);
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == MAG_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done  = done;
  assign res.exact = (rem == '0);
  assign res.root  = root[COMP_W-1:0];

endmodule

### rtl/core/lwe_checker.sv
// ----------------------------------------------------------------------------
// lwe_checker: port-level checks for the lattice wavevector enumerator
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lwe_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        strobe,
  input logic [lwe_pkg::MAG_W-1:0]   corrected_sq_magnitude,
  input logic                        is_last,
  input logic                        truncated
);
  import lwe_pkg::*;

  // Reset leaves the block idle with no result word out
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !strobe)
    else $error("block not idle after reset");

  // An accepted request word makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Result words of one request follow back to back up to the last
  a_burst: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |=> strobe)
    else $error("gap inside a result burst");

  // Magnitude and truncation hold across one burst
  a_burst_stable: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_last |=> $stable(corrected_sq_magnitude) && $stable(truncated))
    else $error("per-request fields changed inside a burst");

  // No result word in the cycle after a request is taken
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !strobe)
    else $error("result word right after a new request");

endmodule

bind lattice_wavevector_enumerator_unit lwe_checker u_lwe_checker (
  .clk                    (clk),
  .rst                    (rst),
  .start                  (start),
  .busy                   (busy),
  .strobe                 (strobe),
  .corrected_sq_magnitude (corrected_sq_magnitude),
  .is_last                (is_last),
  .truncated              (truncated)
);
